// File: hw/rtl/bcc_pkg.sv
package bcc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_ACTIVE_LEVEL = 2'd0;
    localparam logic [1:0] CFG_LONG_TICKS   = 2'd1;
    localparam logic [1:0] CFG_GAP_TICKS    = 2'd2;

    localparam int CFG_ADDR_BITS     = 2;
    localparam int CFG_DATA_BITS     = 16;
    localparam int THRESH_BITS       = 16;
    localparam int CLICK_TOTAL_BITS  = 8;
    localparam int EVENT_BITS        = 3;
    localparam int S_TDATA_BITS      = 8;
    localparam int M_TDATA_BITS      = 16;

    localparam int TICK_COUNT_BITS_DEF  = 16;
    localparam int CLICK_COUNT_BITS_DEF = 8;

    // Reset values of the configuration registers
    localparam logic                   ACTIVE_LEVEL_RST = 1'b0;
    localparam logic [THRESH_BITS-1:0] LONG_TICKS_RST   = 16'd100;
    localparam logic [THRESH_BITS-1:0] GAP_TICKS_RST    = 16'd20;

    localparam logic [CLICK_TOTAL_BITS-1:0] CLICK_TOTAL_MAX = 8'd255;

    typedef enum logic [EVENT_BITS-1:0] {
        EV_NONE    = 3'd0,
        EV_RELEASE = 3'd1,
        EV_LONG    = 3'd2,
        EV_SINGLE  = 3'd3,
        EV_DOUBLE  = 3'd4,
        EV_MORE    = 3'd5
    } t_event;

endpackage

// File: hw/rtl/button_click_classifier.sv
// A result appears on the master side in the cycle after its tick is accepted.
// Throughput: one tick per cycle; the single output register refills in the cycle
// it is taken, so the slave side stalls only while a result waits unread.
// Configuration writes are never stalled: o_cfg_ready is tied high.
// Reset (synchronous, active low): configuration registers return to their defaults, the
// debouncer starts at the inactive level and the press machine at released.
module button_click_classifier #(
    parameter int TICK_COUNT_BITS  = bcc_pkg::TICK_COUNT_BITS_DEF,
    parameter int CLICK_COUNT_BITS = bcc_pkg::CLICK_COUNT_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bcc_pkg::CFG_ADDR_BITS-1:0]    i_cfg_addr,
    input  logic [bcc_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [bcc_pkg::S_TDATA_BITS-1:0]     i_s_axis_tdata,  // [0] pin_level
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [bcc_pkg::M_TDATA_BITS-1:0]     o_m_axis_tdata   // [2:0] event_code,
                                                                  // [10:3] click_total
);

    localparam int TOT_W = (CLICK_COUNT_BITS > bcc_pkg::CLICK_TOTAL_BITS) ?
                           CLICK_COUNT_BITS : bcc_pkg::CLICK_TOTAL_BITS;

    logic                                    r_active_level;
    logic [bcc_pkg::THRESH_BITS-1:0]         r_long_ticks;
    logic [bcc_pkg::THRESH_BITS-1:0]         r_gap_ticks;
    logic                                    r_out_valid;
    bcc_pkg::t_event                         r_event;
    logic [bcc_pkg::CLICK_TOTAL_BITS-1:0]    r_total;

    logic                                    in_accept;
    logic                                    clean;
    logic                                    down;
    bcc_pkg::t_event                         event_code;
    logic [CLICK_COUNT_BITS-1:0]             clicks;
    logic [TOT_W-1:0]                        click_ext;
    logic [bcc_pkg::CLICK_TOTAL_BITS-1:0]    n_total;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_level <= bcc_pkg::ACTIVE_LEVEL_RST;
            r_long_ticks   <= bcc_pkg::LONG_TICKS_RST;
            r_gap_ticks    <= bcc_pkg::GAP_TICKS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                bcc_pkg::CFG_ACTIVE_LEVEL: r_active_level <= i_cfg_data[0];
                bcc_pkg::CFG_LONG_TICKS:   r_long_ticks   <= i_cfg_data;
                bcc_pkg::CFG_GAP_TICKS:    r_gap_ticks    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bcc_debounce u_debounce (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_sample (i_s_axis_tdata[0]),
        .o_clean  (clean)
    );

    assign down = (clean == r_active_level);

    bcc_fsm #(
        .TICK_COUNT_BITS  (TICK_COUNT_BITS),
        .CLICK_COUNT_BITS (CLICK_COUNT_BITS)
    ) u_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_down       (down),
        .i_long_ticks (r_long_ticks),
        .i_gap_ticks  (r_gap_ticks),
        .o_event      (event_code),
        .o_clicks     (clicks)
    );

    // Clamp the click count to the reported range
    assign click_ext = TOT_W'(clicks);
    assign n_total   = (click_ext > TOT_W'(bcc_pkg::CLICK_TOTAL_MAX)) ?
                       bcc_pkg::CLICK_TOTAL_MAX : click_ext[bcc_pkg::CLICK_TOTAL_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_event <= event_code;
            r_total <= n_total;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {
        {(bcc_pkg::M_TDATA_BITS - bcc_pkg::CLICK_TOTAL_BITS - bcc_pkg::EVENT_BITS){1'b0}},
        r_total,
        r_event
    };

`ifndef ASSERT_OFF
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_m_axis_tvalid)
        else $error("accepted tick produced no result");

    a_long_single_click: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (r_event == bcc_pkg::EV_LONG)) |-> (r_total == 8'd1))
        else $error("long click reported with click count other than one");

    a_double_two_clicks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (r_event == bcc_pkg::EV_DOUBLE)) |-> (r_total == 8'd2))
        else $error("double click reported with click count other than two");
`endif

endmodule

// File: hw/rtl/bcc_debounce.sv
module bcc_debounce (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  logic i_sample,
    output logic o_clean
);

    logic r_last;
    logic r_clean;
    logic n_clean;

    // Take the new level only after two equal samples in a row
    assign n_clean = (i_sample == r_last) ? i_sample : r_clean;
    assign o_clean = n_clean;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= ~bcc_pkg::ACTIVE_LEVEL_RST;
            r_clean <= ~bcc_pkg::ACTIVE_LEVEL_RST;
        end else if (i_accept) begin
            r_last  <= i_sample;
            r_clean <= n_clean;
        end
    end

endmodule

// File: hw/rtl/bcc_fsm.sv
module bcc_fsm #(
    parameter int TICK_COUNT_BITS  = bcc_pkg::TICK_COUNT_BITS_DEF,
    parameter int CLICK_COUNT_BITS = bcc_pkg::CLICK_COUNT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic                                i_down,
    input  logic [bcc_pkg::THRESH_BITS-1:0]     i_long_ticks,
    input  logic [bcc_pkg::THRESH_BITS-1:0]     i_gap_ticks,
    output bcc_pkg::t_event                     o_event,
    output logic [CLICK_COUNT_BITS-1:0]         o_clicks
);

    localparam int CMP_W = (TICK_COUNT_BITS > bcc_pkg::THRESH_BITS) ?
                           TICK_COUNT_BITS : bcc_pkg::THRESH_BITS;

    typedef enum logic [2:0] {
        PH_RELEASED      = 3'd0,
        PH_PRESSED       = 3'd1,
        PH_WAITING       = 3'd2,
        PH_PRESSED_AGAIN = 3'd3,
        PH_HELD          = 3'd4
    } t_phase;

    t_phase                        r_phase;
    t_phase                        n_phase;
    logic [TICK_COUNT_BITS-1:0]    r_tick;
    logic [TICK_COUNT_BITS-1:0]    n_tick;
    logic [CLICK_COUNT_BITS-1:0]   r_click;
    logic [CLICK_COUNT_BITS-1:0]   n_click;
    logic [TICK_COUNT_BITS-1:0]    tick_inc;
    logic [CLICK_COUNT_BITS-1:0]   click_inc;
    logic                          long_hit;
    logic                          gap_hit;
    bcc_pkg::t_event               click_ev;

    // Saturating counters: a threshold above the counter range is never reached
    assign tick_inc  = (r_tick == '1) ? r_tick : r_tick + TICK_COUNT_BITS'(1);
    assign click_inc = (r_click == '1) ? r_click : r_click + CLICK_COUNT_BITS'(1);
    assign long_hit  = CMP_W'(tick_inc) >= CMP_W'(i_long_ticks);
    assign gap_hit   = CMP_W'(tick_inc) >= CMP_W'(i_gap_ticks);

    always_comb begin
        if (r_click == '0) begin
            click_ev = bcc_pkg::EV_NONE;
        end else if (r_click == CLICK_COUNT_BITS'(1)) begin
            click_ev = bcc_pkg::EV_SINGLE;
        end else if (r_click == CLICK_COUNT_BITS'(2)) begin
            click_ev = bcc_pkg::EV_DOUBLE;
        end else begin
            click_ev = bcc_pkg::EV_MORE;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_click = r_click;
        o_event = bcc_pkg::EV_NONE;
        case (r_phase)
            PH_PRESSED, PH_PRESSED_AGAIN: begin
                if (!i_down) begin
                    o_event = bcc_pkg::EV_RELEASE;
                    n_tick  = '0;
                    n_phase = PH_WAITING;
                end else begin
                    n_tick = tick_inc;
                    if ((r_phase == PH_PRESSED) ? long_hit : gap_hit) begin
                        o_event = (r_phase == PH_PRESSED) ? bcc_pkg::EV_LONG : click_ev;
                        n_tick  = '0;
                        n_phase = PH_HELD;
                    end
                end
            end
            PH_WAITING: begin
                if (!i_down) begin
                    n_tick = tick_inc;
                    if (gap_hit) begin
                        o_event = click_ev;
                        n_tick  = '0;
                        n_phase = PH_RELEASED;
                    end
                end else begin
                    n_tick  = '0;
                    n_click = click_inc;
                    n_phase = PH_PRESSED_AGAIN;
                end
            end
            PH_HELD: begin
                if (!i_down) begin
                    o_event = bcc_pkg::EV_RELEASE;
                    n_phase = PH_RELEASED;
                end
            end
            default: begin
                n_phase = PH_RELEASED;
                if (i_down) begin
                    n_tick  = '0;
                    n_click = CLICK_COUNT_BITS'(1);
                    n_phase = PH_PRESSED;
                end
            end
        endcase
    end

    assign o_clicks = n_click;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RELEASED;
            r_tick  <= '0;
            r_click <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_click <= n_click;
        end
    end

endmodule

// File: test/button_click_classifier_tb.sv
`timescale 1ns / 1ps

module button_click_classifier_tb;

    localparam int STALL_LIMIT = 200;

    typedef enum logic [2:0] {
        PH_RELEASED,
        PH_PRESSED,
        PH_WAITING,
        PH_PRESSED_AGAIN,
        PH_HELD
    } t_press_phase;

    typedef struct packed {
        bcc_pkg::t_event                      ev;
        logic [bcc_pkg::CLICK_TOTAL_BITS-1:0] clicks;
    } t_click_report;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [bcc_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr = '0;
    logic [bcc_pkg::CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                              i_s_axis_tvalid = 1'b0;
    logic                              o_s_axis_tready;
    logic [bcc_pkg::S_TDATA_BITS-1:0]  i_s_axis_tdata = '0;   // [0] pin_level
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready = 1'b0;
    logic [bcc_pkg::M_TDATA_BITS-1:0]  o_m_axis_tdata;   // [2:0] event_code, [10:3] click_total

    button_click_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Stimulus and scoreboard storage
    logic          pin_samples[$];
    t_click_report pending_reports[$];
    int            queued_ticks = 0;
    int            error_count = 0;

    // Settings the stimulus is shaped for
    logic          stim_active = bcc_pkg::ACTIVE_LEVEL_RST;
    int            stim_long = bcc_pkg::LONG_TICKS_RST;
    int            stim_gap = bcc_pkg::GAP_TICKS_RST;

    // Predictor state
    logic                                     mdl_active;
    logic [bcc_pkg::THRESH_BITS-1:0]          mdl_long;
    logic [bcc_pkg::THRESH_BITS-1:0]          mdl_gap;
    logic                                     mdl_last;
    logic                                     mdl_clean;
    t_press_phase                             mdl_phase;
    logic [bcc_pkg::TICK_COUNT_BITS_DEF-1:0]  mdl_ticks;
    logic [bcc_pkg::CLICK_COUNT_BITS_DEF-1:0] mdl_clicks;

    function automatic bcc_pkg::t_event sequence_event(
        input logic [bcc_pkg::CLICK_COUNT_BITS_DEF-1:0] n
    );
        if (n == 0)
            return bcc_pkg::EV_NONE;
        if (n == 1)
            return bcc_pkg::EV_SINGLE;
        if (n == 2)
            return bcc_pkg::EV_DOUBLE;
        return bcc_pkg::EV_MORE;
    endfunction

    function automatic logic [bcc_pkg::TICK_COUNT_BITS_DEF-1:0] bump_ticks(
        input logic [bcc_pkg::TICK_COUNT_BITS_DEF-1:0] v
    );
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Advance the press machine by one scan tick and report what it emits.
    function automatic t_click_report classify_tick(input logic pin);
        t_click_report r;
        logic          down;
        r.ev = bcc_pkg::EV_NONE;
        if (pin == mdl_last)
            mdl_clean = pin;
        mdl_last = pin;
        down = (mdl_clean == mdl_active);
        case (mdl_phase)
            PH_PRESSED: begin
                if (!down) begin
                    r.ev = bcc_pkg::EV_RELEASE;
                    mdl_ticks = '0;
                    mdl_phase = PH_WAITING;
                end else begin
                    mdl_ticks = bump_ticks(mdl_ticks);
                    if (mdl_ticks >= mdl_long) begin
                        r.ev = bcc_pkg::EV_LONG;
                        mdl_ticks = '0;
                        mdl_phase = PH_HELD;
                    end
                end
            end
            PH_WAITING: begin
                if (!down) begin
                    mdl_ticks = bump_ticks(mdl_ticks);
                    if (mdl_ticks >= mdl_gap) begin
                        r.ev = sequence_event(mdl_clicks);
                        mdl_ticks = '0;
                        mdl_phase = PH_RELEASED;
                    end
                end else begin
                    mdl_ticks = '0;
                    if (mdl_clicks != '1)
                        mdl_clicks = mdl_clicks + 1'b1;
                    mdl_phase = PH_PRESSED_AGAIN;
                end
            end
            PH_PRESSED_AGAIN: begin
                if (!down) begin
                    r.ev = bcc_pkg::EV_RELEASE;
                    mdl_ticks = '0;
                    mdl_phase = PH_WAITING;
                end else begin
                    mdl_ticks = bump_ticks(mdl_ticks);
                    if (mdl_ticks >= mdl_gap) begin
                        r.ev = sequence_event(mdl_clicks);
                        mdl_ticks = '0;
                        mdl_phase = PH_HELD;
                    end
                end
            end
            PH_HELD: begin
                if (!down) begin
                    r.ev = bcc_pkg::EV_RELEASE;
                    mdl_phase = PH_RELEASED;
                end
            end
            default: begin
                mdl_phase = PH_RELEASED;
                if (down) begin
                    mdl_ticks = '0;
                    mdl_clicks = bcc_pkg::CLICK_COUNT_BITS_DEF'(1);
                    mdl_phase = PH_PRESSED;
                end
            end
        endcase
        r.clicks = (mdl_clicks > bcc_pkg::CLICK_TOTAL_MAX) ? bcc_pkg::CLICK_TOTAL_MAX
                                                           : mdl_clicks;
        return r;
    endfunction

    function automatic int idle_draw(input logic calm);
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    // Tick driver
    logic send_calm = 1'b0;
    int   send_wait = 0;

    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            send_wait <= 0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            gap = i_s_axis_tvalid ? idle_draw(send_calm) : send_wait;
            if (i_s_axis_tvalid && $urandom_range(0, 39) == 0)
                send_calm <= !send_calm;
            send_wait <= (gap > 0) ? gap - 1 : 0;
            if (gap != 0) begin
                i_s_axis_tvalid <= 1'b0;
            end else if (pin_samples.size() > 0) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata <= {{(bcc_pkg::S_TDATA_BITS-1){1'b0}}, pin_samples.pop_front()};
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result back-pressure
    logic take_calm = 1'b0;
    int   take_wait = 0;

    always @(posedge i_clk) begin
        int stall;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            take_wait <= 0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            stall = idle_draw(take_calm);
            if ($urandom_range(0, 39) == 0)
                take_calm <= !take_calm;
            i_m_axis_tready <= (stall == 0);
            take_wait <= stall;
        end else if (!i_m_axis_tready) begin
            if (take_wait <= 1)
                i_m_axis_tready <= 1'b1;
            take_wait <= take_wait - 1;
        end
    end

    // Monitor: check results against the oldest expectation, then predict new ticks
    always @(posedge i_clk) begin
        t_click_report want;
        if (!i_rst_n) begin
            mdl_active = bcc_pkg::ACTIVE_LEVEL_RST;
            mdl_long = bcc_pkg::LONG_TICKS_RST;
            mdl_gap = bcc_pkg::GAP_TICKS_RST;
            mdl_last = !bcc_pkg::ACTIVE_LEVEL_RST;
            mdl_clean = !bcc_pkg::ACTIVE_LEVEL_RST;
            mdl_phase = PH_RELEASED;
            mdl_ticks = '0;
            mdl_clicks = '0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected result transaction: tdata 0x%h", o_m_axis_tdata);
                    error_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (o_m_axis_tdata[2:0] !== want.ev) begin
                        $error("event_code: expected %0d, got %0d",
                               want.ev, o_m_axis_tdata[2:0]);
                        error_count++;
                    end
                    if (o_m_axis_tdata[10:3] !== want.clicks) begin
                        $error("click_total: expected %0d, got %0d",
                               want.clicks, o_m_axis_tdata[10:3]);
                        error_count++;
                    end
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready)
                pending_reports.push_back(classify_tick(i_s_axis_tdata[0]));
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_addr)
                    bcc_pkg::CFG_ACTIVE_LEVEL: mdl_active = i_cfg_data[0];
                    bcc_pkg::CFG_LONG_TICKS:   mdl_long = i_cfg_data[bcc_pkg::THRESH_BITS-1:0];
                    bcc_pkg::CFG_GAP_TICKS:    mdl_gap = i_cfg_data[bcc_pkg::THRESH_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Watchdog on cycles without any transaction
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic hold_pin(input logic lvl, input int n);
        repeat (n) begin
            pin_samples.push_back(lvl);
            queued_ticks++;
        end
    endtask

    task automatic press_release(input int on_n, input int off_n);
        hold_pin(stim_active, on_n);
        hold_pin(!stim_active, off_n);
    endtask

    // Mostly well-formed presses around the thresholds, with some raw noise.
    task automatic random_gestures(input int n);
        int start;
        int on_lim;
        int off_lim;
        int pick;
        start = queued_ticks;
        on_lim = (stim_long > 40) ? 40 : stim_long;
        off_lim = (stim_gap > 40) ? 40 : stim_gap;
        while (queued_ticks - start < n) begin
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                repeat ($urandom_range(1, 6))
                    hold_pin(1'($urandom_range(0, 1)), 1);
            end else if (pick == 2 && stim_long <= 200) begin
                press_release(stim_long + $urandom_range(0, 4), $urandom_range(1, 4));
            end else begin
                press_release($urandom_range(1, on_lim + 3), $urandom_range(1, off_lim + 3));
            end
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pin_samples.size() != 0 || i_s_axis_tvalid || pending_reports.size() != 0);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [bcc_pkg::CFG_ADDR_BITS-1:0] addr, input int value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value[bcc_pkg::CFG_DATA_BITS-1:0];
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic act, input int long_t, input int gap_t);
        wait_idle();
        stim_active = act;
        stim_long = long_t;
        stim_gap = gap_t;
        cfg_write(bcc_pkg::CFG_ACTIVE_LEVEL, int'(act));
        cfg_write(bcc_pkg::CFG_LONG_TICKS, long_t);
        cfg_write(bcc_pkg::CFG_GAP_TICKS, gap_t);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults after reset: single, double and long click
        hold_pin(1'b1, 3);
        press_release(4, 24);
        press_release(3, 2);
        press_release(3, 25);
        press_release(104, 3);
        random_gestures(100);

        // Short thresholds: more clicks, hold closing a later press, glitches
        set_config(1'b0, 6, 4);
        press_release(3, 2);
        press_release(3, 2);
        press_release(3, 6);
        press_release(2, 2);
        press_release(7, 3);
        hold_pin(1'b0, 1);
        hold_pin(1'b1, 1);
        hold_pin(1'b0, 1);
        hold_pin(1'b1, 3);
        random_gestures(250);

        // Active level flips without reset: the idle pin now reads as pressed
        set_config(1'b1, 1, 1);
        random_gestures(200);

        // Zero thresholds fire on the first counted tick
        set_config(1'b1, 0, 0);
        random_gestures(100);

        // Widest thresholds: counters stay below them while clicks pile up
        set_config(1'b0, 65535, 65535);
        hold_pin(1'b1, 4);
        repeat (20)
            press_release($urandom_range(2, 4), $urandom_range(2, 4));

        // Close the open sequence with a short gap
        wait_idle();
        stim_gap = 3;
        cfg_write(bcc_pkg::CFG_GAP_TICKS, 3);
        hold_pin(1'b1, 5);

        set_config(1'($urandom_range(0, 1)), $urandom_range(2, 12), $urandom_range(2, 12));
        random_gestures(200);
        set_config(1'($urandom_range(0, 1)), $urandom_range(2, 12), $urandom_range(2, 12));
        random_gestures(150);

        wait_idle();
        repeat (4) @(posedge i_clk);
        if (error_count == 0 && pending_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
